[hdl/tvhc_pkg.sv]
// ----------------------------------------------------------------------------
// Tilt/vibration hazard classifier package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
package tvhc_pkg;

  localparam int unsigned RAD_W   = 32;
  localparam int unsigned ROOT_W  = 16;
  localparam int unsigned REM_W   = 18;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SQ_LAST = 2;
  localparam int unsigned RT_LAST = 15;

  localparam logic [15:0] ONE_G    = 16'd4096;
  localparam logic [15:0] TILT_MAX = 16'd32767;

  localparam logic [1:0] REG_TILT_DANGER = 2'd0;
  localparam logic [1:0] REG_TILT_WARN   = 2'd1;
  localparam logic [1:0] REG_VIB_DANGER  = 2'd2;
  localparam logic [1:0] REG_VIB_WARN    = 2'd3;

  localparam logic [1:0] HAZ_SAFE    = 2'd0;
  localparam logic [1:0] HAZ_WARNING = 2'd1;
  localparam logic [1:0] HAZ_DANGER  = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_SETUP,
    ST_ROOT,
    ST_FINISH
  } tvhc_state_t;

  typedef struct packed {
    logic       load;
    logic       square;
    logic [1:0] sel;
    logic       root_init;
    logic       root_step;
    logic       finish;
  } tvhc_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic slot_free;
  } tvhc_sts_t;

endpackage

[hdl/tvhc_if.sv]
// ----------------------------------------------------------------------------
// Tilt/vibration hazard classifier channels
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tvhc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;

  modport source (output valid, func, accel_x, accel_y, accel_z, pitch_angle, roll_angle,
                  input ready);
  modport sink   (input valid, func, accel_x, accel_y, accel_z, pitch_angle, roll_angle,
                  output ready);
endinterface

interface tvhc_out_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] pitch_out;
  logic signed [15:0] roll_out;
  logic        [14:0] tilt_out;
  logic        [15:0] peak_vibration;
  logic        [1:0]  hazard_status;

  modport source (output valid, pitch_out, roll_out, tilt_out, peak_vibration, hazard_status,
                  input ready);
  modport sink   (input valid, pitch_out, roll_out, tilt_out, peak_vibration, hazard_status,
                  output ready);
endinterface

[hdl/tilt_vibration_hazard_classifier.sv]
// ----------------------------------------------------------------------------
// Tilt/vibration hazard classifier
// Tracks peak vibration from acceleration samples; on a report tick reports
// pitch, roll, tilt, peak and a safe/warning/danger status.
// ----------------------------------------------------------------------------
// One item is worked at a time; a new item is accepted only once the last
// is done. Its steps are an accept state, three square-accumulate steps
// through a single 16x16 multiplier, a root setup state, sixteen steps of a
// two-bit per step restoring square root over the 32-bit sum, and a finish
// state. A report tick writes a result register; if that register still
// holds an untaken transaction, the finish state waits for it. Thresholds
// are written through cfg_we/cfg_index/cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module tilt_vibration_hazard_classifier (
  input  logic         clk,
  input  logic         rst,
  tvhc_in_if.sink      sample_in,
  tvhc_out_if.source   result_out,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  tvhc_pkg::tvhc_cmd_t cmd;
  tvhc_pkg::tvhc_sts_t sts;
  logic in_ready;

  assign sample_in.ready = in_ready;

  tvhc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_in.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tvhc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .func           (sample_in.func),
    .accel_x        (sample_in.accel_x),
    .accel_y        (sample_in.accel_y),
    .accel_z        (sample_in.accel_z),
    .pitch_angle    (sample_in.pitch_angle),
    .roll_angle     (sample_in.roll_angle),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .pitch_out      (result_out.pitch_out),
    .roll_out       (result_out.roll_out),
    .tilt_out       (result_out.tilt_out),
    .peak_vibration (result_out.peak_vibration),
    .hazard_status  (result_out.hazard_status)
  );

endmodule

[hdl/tvhc_ctrl.sv]
// ----------------------------------------------------------------------------
// Tilt/vibration hazard classifier controller
// Sequences load, three squaring steps, root setup, sixteen root steps, finish.
// ----------------------------------------------------------------------------
module tvhc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tvhc_pkg::tvhc_sts_t sts,
  output tvhc_pkg::tvhc_cmd_t cmd
);

  tvhc_pkg::tvhc_state_t state, state_next;
  logic [tvhc_pkg::CNT_W-1:0] count, count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tvhc_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      tvhc_pkg::ST_IDLE: begin
        count_next = '0;
        if (in_valid) state_next = tvhc_pkg::ST_SQUARE;
      end
      tvhc_pkg::ST_SQUARE: begin
        if (count == tvhc_pkg::CNT_W'(tvhc_pkg::SQ_LAST)) begin
          state_next = tvhc_pkg::ST_SETUP;
          count_next = '0;
        end else begin
          count_next = count + 1'b1;
        end
      end
      tvhc_pkg::ST_SETUP: begin
        state_next = tvhc_pkg::ST_ROOT;
        count_next = '0;
      end
      tvhc_pkg::ST_ROOT: begin
        if (count == tvhc_pkg::CNT_W'(tvhc_pkg::RT_LAST)) state_next = tvhc_pkg::ST_FINISH;
        else count_next = count + 1'b1;
      end
      tvhc_pkg::ST_FINISH: begin
        if (!sts.is_tick || sts.slot_free) state_next = tvhc_pkg::ST_IDLE;
      end
      default: state_next = tvhc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    cmd.sel  = count[1:0];
    unique case (state)
      tvhc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tvhc_pkg::ST_SQUARE: cmd.square    = 1'b1;
      tvhc_pkg::ST_SETUP:  cmd.root_init = 1'b1;
      tvhc_pkg::ST_ROOT:   cmd.root_step = 1'b1;
      tvhc_pkg::ST_FINISH: cmd.finish    = !sts.is_tick || sts.slot_free;
      default: ;
    endcase
  end

endmodule

[hdl/tvhc_datapath.sv]
// ----------------------------------------------------------------------------
// Tilt/vibration hazard classifier datapath
// Operand latch, square-accumulate, iterative root, peak, thresholds, result.
// ----------------------------------------------------------------------------
module tvhc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  tvhc_pkg::tvhc_cmd_t cmd,
  output tvhc_pkg::tvhc_sts_t sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                func,
  input  logic signed [15:0]  accel_x,
  input  logic signed [15:0]  accel_y,
  input  logic signed [15:0]  accel_z,
  input  logic signed [15:0]  pitch_angle,
  input  logic signed [15:0]  roll_angle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [15:0]  pitch_out,
  output logic signed [15:0]  roll_out,
  output logic [14:0]         tilt_out,
  output logic [15:0]         peak_vibration,
  output logic [1:0]          hazard_status
);

  logic [14:0] tilt_danger_level, tilt_warning_level;
  logic [15:0] vib_danger_level, vib_warning_level;
  logic [15:0] vibration_peak;

  logic        tick;
  logic [15:0] opnd [3];
  logic signed [15:0] pitch, roll;

  logic [tvhc_pkg::RAD_W-1:0]  acc, rad;
  logic [tvhc_pkg::REM_W-1:0]  rem;
  logic [tvhc_pkg::ROOT_W-1:0] root;

  logic [15:0] sel_abs;
  logic [31:0] sq_val;
  logic [tvhc_pkg::REM_W+1:0] rem_sh, trial;
  logic        take;
  logic [15:0] vib;
  logic [14:0] tilt;
  logic [1:0]  haz;

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_danger_level  <= 15'd1800;
      tilt_warning_level <= 15'd1000;
      vib_danger_level   <= 16'd1229;
      vib_warning_level  <= 16'd410;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tvhc_pkg::REG_TILT_DANGER: tilt_danger_level  <= cfg_data[14:0];
        tvhc_pkg::REG_TILT_WARN:   tilt_warning_level <= cfg_data[14:0];
        tvhc_pkg::REG_VIB_DANGER:  vib_danger_level   <= cfg_data;
        tvhc_pkg::REG_VIB_WARN:    vib_warning_level  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sel_abs = opnd[cmd.sel == 2'd3 ? 2'd2 : cmd.sel];
    if (sel_abs[15]) sel_abs = -sel_abs;
    sq_val = sel_abs * sel_abs;
  end

  always_comb begin
    rem_sh = {rem, rad[tvhc_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    take   = rem_sh >= trial;
  end

  always_comb begin
    vib  = (root >= tvhc_pkg::ONE_G) ? root - tvhc_pkg::ONE_G : tvhc_pkg::ONE_G - root;
    tilt = (root > tvhc_pkg::TILT_MAX) ? tvhc_pkg::TILT_MAX[14:0] : root[14:0];
    if (tilt >= tilt_danger_level || vibration_peak >= vib_danger_level)
      haz = tvhc_pkg::HAZ_DANGER;
    else if (tilt >= tilt_warning_level || vibration_peak >= vib_warning_level)
      haz = tvhc_pkg::HAZ_WARNING;
    else
      haz = tvhc_pkg::HAZ_SAFE;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick  <= func;
      pitch <= pitch_angle;
      roll  <= roll_angle;
      if (func == tvhc_pkg::FUNC_TICK) begin
        opnd[0] <= pitch_angle;
        opnd[1] <= roll_angle;
        opnd[2] <= '0;
      end else begin
        opnd[0] <= accel_x;
        opnd[1] <= accel_y;
        opnd[2] <= accel_z;
      end
      acc <= '0;
    end else if (cmd.square) begin
      acc <= acc + sq_val;
    end
    if (cmd.root_init) begin
      rad  <= acc;
      rem  <= '0;
      root <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[tvhc_pkg::RAD_W-3:0], 2'b00};
      rem  <= take ? tvhc_pkg::REM_W'(rem_sh - trial) : tvhc_pkg::REM_W'(rem_sh);
      root <= {root[tvhc_pkg::ROOT_W-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vibration_peak <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.finish && tick == tvhc_pkg::FUNC_TICK) begin
        vibration_peak <= '0;
        out_valid      <= 1'b1;
      end else begin
        if (cmd.finish && vib > vibration_peak) vibration_peak <= vib;
        if (out_ready) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && tick == tvhc_pkg::FUNC_TICK) begin
      pitch_out      <= pitch;
      roll_out       <= roll;
      tilt_out       <= tilt;
      peak_vibration <= vibration_peak;
      hazard_status  <= haz;
    end
  end

  assign sts.is_tick   = tick;
  assign sts.slot_free = !out_valid || out_ready;

endmodule

[tb/tilt_vibration_hazard_classifier_tb.sv]
// ----------------------------------------------------------------------------
// Tilt/vibration hazard classifier testbench
// Drives acceleration samples and report ticks with random idle on both
// channels, predicts each report from an internal copy of the peak and the
// thresholds, and checks every result transaction field by field in order.
// ----------------------------------------------------------------------------
module tilt_vibration_hazard_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 200;

  typedef struct {
    logic               func;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } sensor_item_t;

  typedef struct {
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
    logic [14:0]        tilt;
    logic [15:0]        peak;
    logic [1:0]         status;
  } hazard_report_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  tvhc_in_if  in_if();
  tvhc_out_if out_if();

  tilt_vibration_hazard_classifier u_top (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (in_if),
    .result_out (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state
  logic [14:0] lvl_tilt_danger;
  logic [14:0] lvl_tilt_warn;
  logic [15:0] lvl_vib_danger;
  logic [15:0] lvl_vib_warn;
  logic [15:0] peak_model;

  hazard_report_t pending_reports[$];
  hazard_report_t want;

  int err_count;
  int snk_gap;
  int sink_hold;
  bit src_idle;
  bit snk_idle;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic log_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic void classify_item(input sensor_item_t it);
    longint sx, sy, sz;
    longint unsigned mag, vib, tilt;
    hazard_report_t rep;
    if (it.func == tvhc_pkg::FUNC_SAMPLE) begin
      sx = it.ax;
      sy = it.ay;
      sz = it.az;
      mag = floor_root(longint'(sx * sx + sy * sy + sz * sz));
      vib = (mag >= tvhc_pkg::ONE_G) ? mag - tvhc_pkg::ONE_G : tvhc_pkg::ONE_G - mag;
      if (vib > peak_model) peak_model = vib[15:0];
    end else begin
      sx = it.pitch;
      sy = it.roll;
      tilt = floor_root(longint'(sx * sx + sy * sy));
      if (tilt > tvhc_pkg::TILT_MAX) tilt = tvhc_pkg::TILT_MAX;
      rep.pitch = it.pitch;
      rep.roll  = it.roll;
      rep.tilt  = tilt[14:0];
      rep.peak  = peak_model;
      if (tilt >= lvl_tilt_danger || peak_model >= lvl_vib_danger)
        rep.status = tvhc_pkg::HAZ_DANGER;
      else if (tilt >= lvl_tilt_warn || peak_model >= lvl_vib_warn)
        rep.status = tvhc_pkg::HAZ_WARNING;
      else
        rep.status = tvhc_pkg::HAZ_SAFE;
      peak_model = '0;
      pending_reports.push_back(rep);
    end
  endfunction

  function automatic sensor_item_t make_sample(input logic signed [15:0] x,
                                               input logic signed [15:0] y,
                                               input logic signed [15:0] z);
    sensor_item_t it;
    it.func  = tvhc_pkg::FUNC_SAMPLE;
    it.ax    = x;
    it.ay    = y;
    it.az    = z;
    it.pitch = 16'($urandom);
    it.roll  = 16'($urandom);
    return it;
  endfunction

  function automatic sensor_item_t make_tick(input logic signed [15:0] p,
                                             input logic signed [15:0] r);
    sensor_item_t it;
    it.func  = tvhc_pkg::FUNC_TICK;
    it.ax    = 16'($urandom);
    it.ay    = 16'($urandom);
    it.az    = 16'($urandom);
    it.pitch = p;
    it.roll  = r;
    return it;
  endfunction

  // returns after the accepting rising edge
  task automatic send_item(input sensor_item_t it);
    int gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.func        = it.func;
    in_if.accel_x     = it.ax;
    in_if.accel_y     = it.ay;
    in_if.accel_z     = it.az;
    in_if.pitch_angle = it.pitch;
    in_if.roll_angle  = it.roll;
    in_if.valid       = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    classify_item(it);
  endtask

  task automatic drain_block();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    case (idx)
      tvhc_pkg::REG_TILT_DANGER: lvl_tilt_danger = data[14:0];
      tvhc_pkg::REG_TILT_WARN:   lvl_tilt_warn   = data[14:0];
      tvhc_pkg::REG_VIB_DANGER:  lvl_vib_danger  = data;
      tvhc_pkg::REG_VIB_WARN:    lvl_vib_warn    = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_levels(input logic [15:0] td, input logic [15:0] tw,
                              input logic [15:0] vd, input logic [15:0] vw);
    write_reg(tvhc_pkg::REG_TILT_DANGER, td);
    write_reg(tvhc_pkg::REG_TILT_WARN, tw);
    write_reg(tvhc_pkg::REG_VIB_DANGER, vd);
    write_reg(tvhc_pkg::REG_VIB_WARN, vw);
  endtask

  function automatic logic signed [15:0] pick_angle();
    if ($urandom_range(0, 99) < 85) return 16'($signed($urandom_range(0, 36000)) - 18000);
    return 16'($urandom);
  endfunction

  function automatic sensor_item_t pick_sample();
    logic signed [15:0] v[3];
    int sel;
    sel = $urandom_range(0, 3);
    case (sel)
      0, 1: begin
        foreach (v[i]) v[i] = 16'($signed($urandom_range(0, 2000)) - 1000);
        v[$urandom_range(0, 2)] = 16'(($urandom_range(0, 1) ? 4096 : -4096)
                                      + $signed($urandom_range(0, 3000)) - 1500);
      end
      2: foreach (v[i]) v[i] = 16'($signed($urandom_range(0, 16384)) - 8192);
      default: foreach (v[i]) v[i] = 16'($urandom);
    endcase
    return make_sample(v[0], v[1], v[2]);
  endfunction

  function automatic logic [15:0] pick_tilt_level();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 25456));
  endfunction

  function automatic logic [15:0] pick_vib_level();
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 3000));
  endfunction

  // result sink: per-transaction gap plus an optional long hold
  initial begin : result_sink
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_if.ready = 1'b0;
        sink_hold--;
      end else if (snk_gap > 0) begin
        out_if.ready = 1'b0;
        snk_gap--;
      end else begin
        out_if.ready = !rst;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      snk_gap = snk_idle ? $urandom_range(0, 4) : 0;
      if (pending_reports.size() == 0) begin
        log_mismatch($sformatf("unexpected result pitch=%0d roll=%0d",
                               out_if.pitch_out, out_if.roll_out));
      end else begin
        want = pending_reports.pop_front();
        if (out_if.pitch_out !== want.pitch)
          log_mismatch($sformatf("pitch_out %0d, want %0d", out_if.pitch_out, want.pitch));
        if (out_if.roll_out !== want.roll)
          log_mismatch($sformatf("roll_out %0d, want %0d", out_if.roll_out, want.roll));
        if (out_if.tilt_out !== want.tilt)
          log_mismatch($sformatf("tilt_out %0d, want %0d", out_if.tilt_out, want.tilt));
        if (out_if.peak_vibration !== want.peak)
          log_mismatch($sformatf("peak_vibration %0d, want %0d",
                                 out_if.peak_vibration, want.peak));
        if (out_if.hazard_status !== want.status)
          log_mismatch($sformatf("hazard_status %0d, want %0d",
                                 out_if.hazard_status, want.status));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tilt_vibration_hazard_classifier_tb: errors");
    $finish;
  end

  // thresholds at their reset values
  task automatic reset_levels_test();
    send_item(make_tick(0, 0));
    send_item(make_tick(999, 0));
    send_item(make_tick(1000, 0));
    send_item(make_tick(0, -1799));
    send_item(make_tick(-1800, 0));
    send_item(make_tick(18000, 18000));
    send_item(make_tick(-18000, -18000));
    send_item(make_tick(-32768, -32768));
    send_item(make_tick(32767, 32767));
    send_item(make_sample(4096, 0, 0));
    send_item(make_sample(4505, 0, 0));
    send_item(make_tick(0, 0));
    send_item(make_sample(4506, 0, 0));
    send_item(make_tick(0, 0));
    send_item(make_sample(0, 0, 2868));
    send_item(make_sample(0, 0, 2867));
    send_item(make_tick(0, 0));
    send_item(make_sample(0, 5000, 0));
    send_item(make_sample(0, -5000, 0));
    send_item(make_tick(0, 0));
    send_item(make_sample(-32768, -32768, -32768));
    send_item(make_sample(32767, 32767, 32767));
    send_item(make_tick(100, -100));
    send_item(make_sample(0, 0, 0));
    send_item(make_tick(-1, 1));
  endtask

  // zero, all-ones and mixed thresholds
  task automatic level_extremes_test();
    drain_block();
    write_levels(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(make_tick(0, 0));
    send_item(make_sample(4096, 0, 0));
    send_item(make_tick(1, 0));
    drain_block();
    write_levels(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(make_tick(18000, 18000));
    send_item(make_tick(32767, 32767));
    send_item(make_sample(-32768, -32768, -32768));
    send_item(make_tick(-18000, 0));
    drain_block();
    write_levels(16'd500, 16'd0, 16'd2000, 16'd65535);
    send_item(make_tick(499, 0));
    send_item(make_tick(0, 500));
  endtask

  task automatic random_traffic_test();
    for (int phase = 0; phase < 4; phase++) begin
      drain_block();
      write_levels(pick_tilt_level(), pick_tilt_level(), pick_vib_level(), pick_vib_level());
      for (int n = 0; n < 400; n++) begin
        if (n % 40 == 0) begin
          src_idle = ($urandom_range(0, 3) != 0);
          snk_idle = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 4) == 0)
          send_item(make_tick(pick_angle(), pick_angle()));
        else
          send_item(pick_sample());
      end
    end
    src_idle = 1'b1;
    snk_idle = 1'b1;
  endtask

  // long sink hold fills the block and stalls input, then sender waits out the backlog
  task automatic backpressure_test();
    drain_block();
    write_levels(16'd1800, 16'd1000, 16'd1229, 16'd410);
    @(posedge clk);
    sink_hold = LONG_HOLD;
    for (int n = 0; n < 40; n++) begin
      if (n % 2 == 0)
        send_item(make_tick(pick_angle(), pick_angle()));
      else
        send_item(pick_sample());
    end
    drain_block();
    for (int n = 0; n < 20; n++) send_item(make_tick(pick_angle(), pick_angle()));
  endtask

  initial begin : main_seq
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_if.valid       = 1'b0;
    in_if.func        = tvhc_pkg::FUNC_SAMPLE;
    in_if.accel_x     = '0;
    in_if.accel_y     = '0;
    in_if.accel_z     = '0;
    in_if.pitch_angle = '0;
    in_if.roll_angle  = '0;
    err_count         = 0;
    snk_gap           = 0;
    sink_hold         = 0;
    src_idle          = 1'b1;
    snk_idle          = 1'b1;
    lvl_tilt_danger   = 15'd1800;
    lvl_tilt_warn     = 15'd1000;
    lvl_vib_danger    = 16'd1229;
    lvl_vib_warn      = 16'd410;
    peak_model        = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    reset_levels_test();
    level_extremes_test();
    random_traffic_test();
    backpressure_test();
    drain_block();

    if (err_count == 0)
      $display("tilt_vibration_hazard_classifier_tb: clean");
    else
      $display("tilt_vibration_hazard_classifier_tb: errors");
    $finish;
  end

endmodule

[sim.f]
hdl/tvhc_pkg.sv
hdl/tvhc_if.sv
hdl/tvhc_ctrl.sv
hdl/tvhc_datapath.sv
hdl/tilt_vibration_hazard_classifier.sv
tb/tilt_vibration_hazard_classifier_tb.sv
